@@ rtl/smd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package smd_pkg;

	// matrix geometry
	localparam int MAX_DIM = 16;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int CNT_W   = IDX_W + 1;
	localparam int TERM_W  = IDX_W + 1;

	// field widths
	localparam int DIM_W   = 5;
	localparam int VAL_W   = 32;
	localparam int DIFF_W  = VAL_W + 1;
	localparam int DIST_W  = 64;

	// item modes
	localparam logic MODE_COEF = 1'b0;
	localparam logic MODE_PAIR = 1'b1;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} smd_state_t;

endpackage
`default_nettype wire

@@ rtl/smd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface smd_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [smd_pkg::IDX_W-1:0]     row;
	logic [smd_pkg::IDX_W-1:0]     col;
	logic signed [smd_pkg::VAL_W-1:0] coef_value;
	logic signed [smd_pkg::VAL_W-1:0] x_value;
	logic signed [smd_pkg::VAL_W-1:0] y_value;

	modport source (output valid, mode, row, col, coef_value, x_value, y_value,
		input ready);
	modport sink (input valid, mode, row, col, coef_value, x_value, y_value,
		output ready);
endinterface

// result item channel
interface smd_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [smd_pkg::DIST_W-1:0] distance;
	logic                              overflow;

	modport source (output valid, distance, overflow, input ready);
	modport sink (input valid, distance, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/squared_mahalanobis_distance_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel    dir   handshake      payload
// in_ch      in    valid/ready    mode, row, col, coef_value, x_value, y_value
// out_ch     out   valid/ready    distance, overflow
// dim        in    dim_we         dim_wdata (5 bits)
//
// a matrix write item is stored when it is accepted; an element pair item k
// (0-based within its vector) issues 2k+1 terms after its accept, into the
// single multiply chain that forms one term per cycle, unless stalled, from the
// matrix and diff memories
// arst_n clears the sequencer, count, accumulator and output valid; the memories
// are not cleared. a final term stalls the pipeline while a result still waits
module squared_mahalanobis_distance_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            dim_we,
	input  wire [smd_pkg::DIM_W-1:0]       dim_wdata,
	smd_in_if.sink                         in_ch,
	smd_out_if.source                      out_ch
);

	localparam logic [smd_pkg::DIST_W-1:0] POS_MAX = {1'b0, {(smd_pkg::DIST_W-1){1'b1}}};
	localparam logic [smd_pkg::DIST_W-1:0] NEG_MAX = {1'b1, {(smd_pkg::DIST_W-1){1'b0}}};
	localparam int LO_W   = smd_pkg::VAL_W + smd_pkg::DIFF_W;
	localparam int PROD_W = LO_W + smd_pkg::VAL_W;

	// configuration
	logic [smd_pkg::DIM_W-1:0] dim_q;
	logic [smd_pkg::DIM_W-1:0] eff_dim;

	// sequencer
	smd_pkg::smd_state_t        state_q, state_d;
	logic [smd_pkg::TERM_W-1:0] term_q, term_d;
	logic [smd_pkg::IDX_W-1:0]  count_q;
	logic [smd_pkg::IDX_W-1:0]  k_q;
	logic                       fin_q;
	logic [smd_pkg::DIFF_W-1:0] dk_mag_q;
	logic                       dk_neg_q;
	logic                       rd_en;
	logic                       adv;
	logic                       pipe_busy;
	logic                       in_acc;
	logic [smd_pkg::TERM_W-1:0] last_term;
	logic [smd_pkg::IDX_W-1:0]  jj;
	logic [smd_pkg::ADDR_W-1:0] mat_raddr;
	logic [smd_pkg::IDX_W-1:0]  diff_raddr;
	logic signed [smd_pkg::DIFF_W-1:0] dk_in;
	logic [smd_pkg::DIFF_W-1:0] dk_in_mag;

	// memories
	logic [smd_pkg::VAL_W-1:0]  mat_mem [smd_pkg::MAX_DIM*smd_pkg::MAX_DIM];
	logic [smd_pkg::DIFF_W-1:0] diff_mem [smd_pkg::MAX_DIM];

	// pipeline
	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic                       last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic                       neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [smd_pkg::VAL_W-1:0]  mat_rd_s1;
	logic [smd_pkg::DIFF_W-1:0] diff_rd_s1;
	logic [smd_pkg::VAL_W-1:0]  s_mag;
	logic [smd_pkg::DIFF_W-1:0] dj_mag;
	logic [LO_W-1:0]            p_s2;
	logic [smd_pkg::DIFF_W-1:0] mb_s2, mb_s3;
	logic [LO_W-1:0]            lo_s3, lo_s4;
	logic [smd_pkg::VAL_W-1:0]  ph_s3;
	logic [LO_W-1:0]            mid_s4;
	logic [PROD_W-1:0]          prod_s5;
	logic [PROD_W-1:0]          rnd;
	logic [PROD_W-17:0]         q_full;
	logic [smd_pkg::DIST_W-1:0] limit;
	logic                       term_sat;
	logic [smd_pkg::DIST_W-1:0] qm_s6;
	logic                       sat_s6, sat_s7;
	logic [smd_pkg::DIST_W-1:0] t_s7;

	// accumulator and result
	logic [smd_pkg::DIST_W-1:0] acc_q;
	logic                       sat_q;
	logic [smd_pkg::DIST_W-1:0] sum;
	logic                       acc_ovf;
	logic [smd_pkg::DIST_W-1:0] acc_new;
	logic                       sat_new;
	logic                       out_valid_q;
	logic [smd_pkg::DIST_W-1:0] out_dist_q;
	logic                       out_ovf_q;

	// dim register and its clamped value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= smd_pkg::DIM_W'(1);
		end else if (dim_we) begin
			dim_q <= dim_wdata;
		end
	end

	always_comb begin
		if (dim_q == '0) begin
			eff_dim = smd_pkg::DIM_W'(1);
		end else if (dim_q > smd_pkg::DIM_W'(smd_pkg::MAX_DIM)) begin
			eff_dim = smd_pkg::DIM_W'(smd_pkg::MAX_DIM);
		end else begin
			eff_dim = dim_q;
		end
	end

	// input handshake
	assign pipe_busy   = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7;
	assign in_ch.ready = (state_q == smd_pkg::ST_IDLE) && !pipe_busy;
	assign in_acc      = in_ch.valid && in_ch.ready;

	// exact difference and its magnitude
	assign dk_in     = {in_ch.x_value[smd_pkg::VAL_W-1], in_ch.x_value}
		- {in_ch.y_value[smd_pkg::VAL_W-1], in_ch.y_value};
	assign dk_in_mag = dk_in[smd_pkg::DIFF_W-1] ? (~dk_in + 1'b1) : dk_in;

	// item capture and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			fin_q   <= 1'b0;
		end else if (in_acc && in_ch.mode == smd_pkg::MODE_PAIR) begin
			k_q <= count_q;
			if (({1'b0, count_q} + 1'b1) >= eff_dim) begin
				fin_q   <= 1'b1;
				count_q <= '0;
			end else begin
				fin_q   <= 1'b0;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.mode == smd_pkg::MODE_PAIR) begin
			dk_mag_q <= dk_in_mag;
			dk_neg_q <= dk_in[smd_pkg::DIFF_W-1];
		end
	end

	// term sequencer: term 0 is the diagonal, odd terms S[k][j], even terms S[j][k]
	assign last_term = {k_q, 1'b0};
	assign jj        = term_q[0] ? term_q[smd_pkg::TERM_W-1:1]
		: term_q[smd_pkg::TERM_W-1:1] - 1'b1;

	always_comb begin
		if (term_q == '0) begin
			mat_raddr  = {k_q, k_q};
			diff_raddr = k_q;
		end else if (term_q[0]) begin
			mat_raddr  = {k_q, jj};
			diff_raddr = jj;
		end else begin
			mat_raddr  = {jj, k_q};
			diff_raddr = jj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smd_pkg::ST_IDLE;
			term_q  <= '0;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
		end
	end

	always_comb begin
		state_d = state_q;
		term_d  = term_q;
		rd_en   = 1'b0;
		case (state_q)
			smd_pkg::ST_IDLE: begin
				if (in_acc && in_ch.mode == smd_pkg::MODE_PAIR) begin
					state_d = smd_pkg::ST_RUN;
					term_d  = '0;
				end
			end
			smd_pkg::ST_RUN: begin
				if (adv) begin
					rd_en = 1'b1;
					if (term_q == last_term) begin
						state_d = smd_pkg::ST_IDLE;
					end else begin
						term_d = term_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = smd_pkg::ST_IDLE;
			end
		endcase
	end

	// matrix memory
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.mode == smd_pkg::MODE_COEF) begin
			mat_mem[{in_ch.row, in_ch.col}] <= in_ch.coef_value;
		end
		if (rd_en) begin
			mat_rd_s1 <= mat_mem[mat_raddr];
		end
	end

	// diff memory
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.mode == smd_pkg::MODE_PAIR) begin
			diff_mem[count_q] <= dk_in;
		end
		if (rd_en) begin
			diff_rd_s1 <= diff_mem[diff_raddr];
		end
	end

	// pipeline stalls only when a final term meets a waiting result
	assign adv = !(v_s7 && last_s7 && fin_q && out_valid_q && !out_ch.ready);

	// control flags along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// operand magnitudes
	assign s_mag  = mat_rd_s1[smd_pkg::VAL_W-1] ? (~mat_rd_s1 + 1'b1) : mat_rd_s1;
	assign dj_mag = diff_rd_s1[smd_pkg::DIFF_W-1] ? (~diff_rd_s1 + 1'b1) : diff_rd_s1;

	// rounding and saturation of one term to q32.32
	assign rnd      = prod_s5 + PROD_W'(16'h8000);
	assign q_full   = rnd[PROD_W-1:16];
	assign limit    = neg_s5 ? NEG_MAX : POS_MAX;
	assign term_sat = (|q_full[PROD_W-17:smd_pkg::DIST_W])
		|| (q_full[smd_pkg::DIST_W-1:0] > limit);

	// payload stages of the term chain
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= (term_q == last_term);
			// stage 2: |s| * |dk|
			p_s2    <= LO_W'(s_mag) * LO_W'(dk_mag_q);
			mb_s2   <= dj_mag;
			neg_s2  <= mat_rd_s1[smd_pkg::VAL_W-1] ^ dk_neg_q
				^ diff_rd_s1[smd_pkg::DIFF_W-1];
			last_s2 <= last_s1;
			// stage 3: low half times |dj|
			lo_s3   <= LO_W'(p_s2[smd_pkg::VAL_W-1:0]) * LO_W'(mb_s2);
			ph_s3   <= p_s2[LO_W-2:smd_pkg::VAL_W];
			mb_s3   <= mb_s2;
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
			// stage 4: high half times |dj|
			mid_s4  <= LO_W'(ph_s3) * LO_W'(mb_s3);
			lo_s4   <= lo_s3;
			neg_s4  <= neg_s3;
			last_s4 <= last_s3;
			// stage 5: full exact magnitude
			prod_s5 <= {{smd_pkg::VAL_W{1'b0}}, lo_s4} + {mid_s4, {smd_pkg::VAL_W{1'b0}}};
			neg_s5  <= neg_s4;
			last_s5 <= last_s4;
			// stage 6: rounded and clamped magnitude
			qm_s6   <= term_sat ? limit : q_full[smd_pkg::DIST_W-1:0];
			sat_s6  <= term_sat;
			neg_s6  <= neg_s5;
			last_s6 <= last_s5;
			// stage 7: signed term
			t_s7    <= neg_s6 ? (~qm_s6 + 1'b1) : qm_s6;
			sat_s7  <= sat_s6;
			last_s7 <= last_s6;
		end
	end

	// saturating accumulate
	assign sum     = acc_q + t_s7;
	assign acc_ovf = (acc_q[smd_pkg::DIST_W-1] == t_s7[smd_pkg::DIST_W-1])
		&& (sum[smd_pkg::DIST_W-1] != acc_q[smd_pkg::DIST_W-1]);
	assign acc_new = acc_ovf ? (acc_q[smd_pkg::DIST_W-1] ? NEG_MAX : POS_MAX) : sum;
	assign sat_new = sat_q | sat_s7 | acc_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_s7 && adv) begin
				if (last_s7 && fin_q) begin
					acc_q       <= '0;
					sat_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					acc_q <= acc_new;
					sat_q <= sat_new;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (v_s7 && adv && last_s7 && fin_q) begin
			out_dist_q <= acc_new;
			out_ovf_q  <= sat_new;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.distance = out_dist_q;
	assign out_ch.overflow = out_ovf_q;

endmodule
`default_nettype wire
